FILE: rtl/core/rbsvr_pkg.sv
// Package with shared constants, types and helper functions of the rigid body step block.
`timescale 1ns / 1ps
`default_nettype none

package rbsvr_pkg;

    localparam int VERTEX_COUNT = 32;
    localparam int VIDX_W       = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int CW           = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam int APB_AW = 5;

    localparam logic [2:0] REG_START_POS_X  = 3'd0;
    localparam logic [2:0] REG_START_POS_Y  = 3'd1;
    localparam logic [2:0] REG_START_VEL_X  = 3'd2;
    localparam logic [2:0] REG_START_VEL_Y  = 3'd3;
    localparam logic [2:0] REG_ANGULAR_STEP = 3'd4;
    localparam logic [2:0] REG_INVERSE_MASS = 3'd5;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_LOAD     = 2'd1;
    localparam logic [1:0] OP_RESTART  = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_LOAD    = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         vertex_index;
        logic signed [31:0] model_x;
        logic signed [31:0] model_y;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] bound_left;
        logic signed [31:0] bound_top;
        logic signed [31:0] bound_width;
        logic signed [31:0] bound_height;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] start_pos_x;
        logic signed [31:0] start_pos_y;
        logic signed [31:0] start_vel_x;
        logic signed [31:0] start_vel_y;
        logic signed [15:0] angular_step;
        logic [16:0]        inverse_mass;
    } cfg_t;

    typedef struct packed {
        logic idle;
        logic pop;
    } back_status_t;

    function automatic logic signed [16:0] atan_turn(input logic [STEP_W-1:0] i);
        logic signed [16:0] r;
        case (i)
            4'd0:    r = 17'sd8192;
            4'd1:    r = 17'sd4836;
            4'd2:    r = 17'sd2555;
            4'd3:    r = 17'sd1297;
            4'd4:    r = 17'sd651;
            4'd5:    r = 17'sd326;
            4'd6:    r = 17'sd163;
            4'd7:    r = 17'sd81;
            4'd8:    r = 17'sd41;
            4'd9:    r = 17'sd20;
            4'd10:   r = 17'sd10;
            4'd11:   r = 17'sd5;
            4'd12:   r = 17'sd3;
            4'd13:   r = 17'sd1;
            4'd14:   r = 17'sd1;
            default: r = 17'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -40'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic in_span(input logic signed [31:0] p,
                                     input logic signed [31:0] edge_v,
                                     input logic signed [31:0] size_v);
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic signed [32:0] lo;
        logic signed [32:0] hi;
        logic signed [32:0] pe;
        a  = {edge_v[31], edge_v};
        b  = a + {size_v[31], size_v};
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        pe = {p[31], p};
        return (pe >= lo) && (pe < hi);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rbsvr_if.sv
// Valid/ready channel interfaces for command transactions and vertex result transactions.
`timescale 1ns / 1ps
`default_nettype none

interface rbsvr_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [5:0]         vertex_index;
    logic signed [31:0] model_x;
    logic signed [31:0] model_y;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] bound_left;
    logic signed [31:0] bound_top;
    logic signed [31:0] bound_width;
    logic signed [31:0] bound_height;

    modport source (output valid, opcode, vertex_index, model_x, model_y, force_x, force_y,
                    bound_left, bound_top, bound_width, bound_height, input ready);
    modport sink (input valid, opcode, vertex_index, model_x, model_y, force_x, force_y,
                  bound_left, bound_top, bound_width, bound_height, output ready);
endinterface

interface rbsvr_res_if;
    logic               valid;
    logic               ready;
    logic [5:0]         vertex_number;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic               inside_bounds;
    logic               last_vertex;

    modport source (output valid, vertex_number, world_x, world_y, inside_bounds, last_vertex,
                    input ready);
    modport sink (input valid, vertex_number, world_x, world_y, inside_bounds, last_vertex,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rigid_body_step_vertex_rotate.sv
// Top level of the rigid body step block: configuration registers, front end and back end.
`timescale 1ns / 1ps
`default_nettype none
//
// The block advances a 2D rigid body by one semi-implicit Euler step per tick and then
// emits one result transaction per vertex storage entry, rotated by the body heading and
// moved to the body position. Load commands store a model vertex; restart commands copy the
// configured start position and velocity into the body and clear the heading.
// Commands arrive on the cmd channel and results leave on the res channel, both valid/ready.
// A two-entry queue sits between the front end, which accepts and classifies commands, and
// the back end, which executes them one at a time, so the cmd side keeps accepting until the
// queue is full while the back end is busy or the receiver stalls.
// A tick first runs setup (force multiply, velocity, position, bounds test, 16 sine/cosine
// iterations, quadrant mapping) and then streams one vertex per cycle while res.ready allows
// it, through a three-stage pipeline (memory read, four products, round and saturate).
// Load, restart and no-op commands are executed as they are popped in the idle state.
// With a result waiting and res.ready low, the whole pipeline holds; nothing is dropped.
// Reset clears the body state, the queue and the pipeline and loads the register defaults;
// vertex storage is undefined until loaded. Registers are written over the APB port; the
// user must write them only while the block is idle, which the block does not enforce.
//
module rigid_body_step_vertex_rotate
    import rbsvr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    rbsvr_cmd_if.sink              cmd,
    rbsvr_res_if.source            res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    cfg_t         cfg_reg;
    cmd_t         head;
    logic         head_valid;
    back_status_t status;
    logic         wr_en;
    logic [2:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_AW-1:2];

    // Register file; writes beyond the last register are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_pos_x  <= '0;
            cfg_reg.start_pos_y  <= '0;
            cfg_reg.start_vel_x  <= '0;
            cfg_reg.start_vel_y  <= '0;
            cfg_reg.angular_step <= '0;
            cfg_reg.inverse_mass <= 17'h10000;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_START_POS_X:  cfg_reg.start_pos_x  <= pwdata;
                REG_START_POS_Y:  cfg_reg.start_pos_y  <= pwdata;
                REG_START_VEL_X:  cfg_reg.start_vel_x  <= pwdata;
                REG_START_VEL_Y:  cfg_reg.start_vel_y  <= pwdata;
                REG_ANGULAR_STEP: cfg_reg.angular_step <= pwdata[15:0];
                REG_INVERSE_MASS: cfg_reg.inverse_mass <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_START_POS_X:  prdata = cfg_reg.start_pos_x;
            REG_START_POS_Y:  prdata = cfg_reg.start_pos_y;
            REG_START_VEL_X:  prdata = cfg_reg.start_vel_x;
            REG_START_VEL_Y:  prdata = cfg_reg.start_vel_y;
            REG_ANGULAR_STEP: prdata = {16'b0, cfg_reg.angular_step};
            REG_INVERSE_MASS: prdata = {15'b0, cfg_reg.inverse_mass};
            default:          prdata = '0;
        endcase
    end

    rbsvr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .head       (head),
        .head_valid (head_valid),
        .pop        (status.pop)
    );

    rbsvr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .cfg        (cfg_reg),
        .status     (status),
        .res        (res)
    );

    // The back end only takes a command from a non-empty queue, and only when idle.
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        status.pop |-> (head_valid && status.idle))
        else $error("command popped from empty queue or while busy");

    // The end-of-tick flag goes with the final vertex only.
    a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.last_vertex) |-> (res.vertex_number == 6'(VERTEX_COUNT - 1)))
        else $error("last_vertex on wrong vertex");

    // No new result is offered once the back end has stayed idle long enough to empty the pipeline.
    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        (status.idle && $past(status.idle) && $past(status.idle, 2) && $past(status.idle, 3)
         && $past(status.idle, 4)) |-> !res.valid || $past(res.valid))
        else $error("result appeared while back end idle");

endmodule

`default_nettype wire

FILE: rtl/core/rbsvr_front.sv
// Front end: accepts command transactions, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module rbsvr_front
    import rbsvr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    rbsvr_cmd_if.sink   cmd,
    output cmd_t        head,
    output logic        head_valid,
    input  wire logic   pop
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    cmd_t       classified;

    // Out-of-range loads and the unused opcode are turned into no-ops here.
    always_comb
    begin
        classified.vertex_index = cmd.vertex_index;
        classified.model_x      = cmd.model_x;
        classified.model_y      = cmd.model_y;
        classified.force_x      = cmd.force_x;
        classified.force_y      = cmd.force_y;
        classified.bound_left   = cmd.bound_left;
        classified.bound_top    = cmd.bound_top;
        classified.bound_width  = cmd.bound_width;
        classified.bound_height = cmd.bound_height;
        case (cmd.opcode)
            OP_TICK:    classified.kind = KIND_TICK;
            OP_RESTART: classified.kind = KIND_RESTART;
            OP_LOAD:
            begin
                if ({1'b0, cmd.vertex_index} < 7'(VERTEX_COUNT))
                    classified.kind = KIND_LOAD;
                else
                    classified.kind = KIND_NONE;
            end
            default:    classified.kind = KIND_NONE;
        endcase
    end

    assign cmd.ready  = (count_reg != 2'd2);
    assign push       = cmd.valid && cmd.ready;
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && head_valid))
            count_next = count_reg + 2'd1;
        else if (!push && pop && head_valid)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop && head_valid)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= classified;
    end

endmodule

`default_nettype wire

FILE: rtl/core/rbsvr_back.sv
// Back end: body state update, sine/cosine iteration and the vertex rotation pipeline.
`timescale 1ns / 1ps
`default_nettype none

module rbsvr_back
    import rbsvr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cmd_t    head,
    input  wire logic    head_valid,
    input  wire cfg_t    cfg,
    output back_status_t status,
    rbsvr_res_if.source  res
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_VEL   = 4'd2;
    localparam logic [3:0] ST_POS   = 4'd3;
    localparam logic [3:0] ST_BND   = 4'd4;
    localparam logic [3:0] ST_ROT   = 4'd5;
    localparam logic [3:0] ST_MAP   = 4'd6;
    localparam logic [3:0] ST_VTX   = 4'd7;
    localparam logic [3:0] ST_DRAIN = 4'd8;

    logic [3:0] state_reg;
    cmd_t       cmd_reg;

    logic signed [31:0] vel_x_reg, vel_y_reg, pos_x_reg, pos_y_reg;
    logic [15:0]        heading_reg;
    logic signed [49:0] dv_x_reg, dv_y_reg;
    logic               inside_reg;

    logic signed [CW-1:0] cx_reg, cy_reg, c_reg, s_reg;
    logic signed [16:0]   z_reg;
    logic [1:0]           quad_reg;
    logic [STEP_W-1:0]    it_reg;

    logic [63:0]       mem [VERTEX_COUNT];
    logic [VIDX_W-1:0] cnt_reg;
    logic              v1_reg, v2_reg, out_valid_reg;
    logic [VIDX_W-1:0] n1_reg, n2_reg, out_num_reg;
    logic              l1_reg, l2_reg, out_last_reg;
    logic              out_inside_reg;
    logic [63:0]       rd_reg;
    logic signed [65:0] xc_reg, ys_reg, xs_reg, yc_reg;
    logic signed [31:0] out_x_reg, out_y_reg;

    logic pop;
    logic en;
    logic issue;

    logic signed [50:0] rnd_x, rnd_y;
    logic signed [39:0] vsum_x, vsum_y;
    logic signed [39:0] psum_x, psum_y;
    logic signed [CW-1:0] sh_x, sh_y;
    logic signed [66:0] acc_x, acc_y;
    logic signed [39:0] wsum_x, wsum_y;

    assign pop    = (state_reg == ST_IDLE) && head_valid;
    assign status = '{idle: (state_reg == ST_IDLE), pop: pop};
    assign en     = !out_valid_reg || res.ready;
    assign issue  = (state_reg == ST_VTX) && en;

    always_comb
    begin
        rnd_x  = 51'(dv_x_reg) + 51'sd32768;
        rnd_y  = 51'(dv_y_reg) + 51'sd32768;
        vsum_x = 40'(vel_x_reg) + 40'($signed(rnd_x[50:16]));
        vsum_y = 40'(vel_y_reg) + 40'($signed(rnd_y[50:16]));
        psum_x = 40'(pos_x_reg) + 40'(vel_x_reg);
        psum_y = 40'(pos_y_reg) + 40'(vel_y_reg);
        sh_x   = cx_reg >>> it_reg;
        sh_y   = cy_reg >>> it_reg;
        acc_x  = 67'(xc_reg) - 67'(ys_reg) + 67'sd536870912;
        acc_y  = 67'(xs_reg) + 67'(yc_reg) + 67'sd536870912;
        wsum_x = 40'($signed(acc_x[66:30])) + 40'(pos_x_reg);
        wsum_y = 40'($signed(acc_y[66:30])) + 40'(pos_y_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            it_reg        <= '0;
            cnt_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        case (head.kind)
                            KIND_TICK: state_reg <= ST_MUL;
                            KIND_RESTART:
                            begin
                                pos_x_reg   <= cfg.start_pos_x;
                                pos_y_reg   <= cfg.start_pos_y;
                                vel_x_reg   <= cfg.start_vel_x;
                                vel_y_reg   <= cfg.start_vel_y;
                                heading_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MUL: state_reg <= ST_VEL;
                ST_VEL:
                begin
                    vel_x_reg <= sat32(vsum_x);
                    vel_y_reg <= sat32(vsum_y);
                    state_reg <= ST_POS;
                end
                ST_POS:
                begin
                    pos_x_reg   <= sat32(psum_x);
                    pos_y_reg   <= sat32(psum_y);
                    heading_reg <= heading_reg + 16'(cfg.angular_step);
                    state_reg   <= ST_BND;
                end
                ST_BND:
                begin
                    it_reg    <= '0;
                    state_reg <= ST_ROT;
                end
                ST_ROT:
                begin
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == STEP_W'(CORDIC_STEPS - 1))
                        state_reg <= ST_MAP;
                end
                ST_MAP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_VTX;
                end
                ST_VTX:
                begin
                    if (en)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == VIDX_W'(VERTEX_COUNT - 1))
                            state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (en)
            begin
                v1_reg        <= issue;
                v2_reg        <= v1_reg;
                out_valid_reg <= v2_reg;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= head;
        if (pop && head.kind == KIND_LOAD)
            mem[head.vertex_index[VIDX_W-1:0]] <= {head.model_x, head.model_y};

        if (state_reg == ST_MUL)
        begin
            dv_x_reg <= cmd_reg.force_x * $signed({1'b0, cfg.inverse_mass});
            dv_y_reg <= cmd_reg.force_y * $signed({1'b0, cfg.inverse_mass});
        end

        if (state_reg == ST_BND)
        begin
            inside_reg <= in_span(pos_x_reg, cmd_reg.bound_left, cmd_reg.bound_width) &&
                          in_span(pos_y_reg, cmd_reg.bound_top, cmd_reg.bound_height);
            cx_reg   <= CORDIC_GAIN;
            cy_reg   <= '0;
            z_reg    <= {3'b000, heading_reg[13:0]};
            quad_reg <= heading_reg[15:14];
        end

        if (state_reg == ST_ROT)
        begin
            if (!z_reg[16])
            begin
                cx_reg <= cx_reg - sh_y;
                cy_reg <= cy_reg + sh_x;
                z_reg  <= z_reg - atan_turn(it_reg);
            end
            else
            begin
                cx_reg <= cx_reg + sh_y;
                cy_reg <= cy_reg - sh_x;
                z_reg  <= z_reg + atan_turn(it_reg);
            end
        end

        if (state_reg == ST_MAP)
        begin
            case (quad_reg)
                2'd0:
                begin
                    c_reg <= cx_reg;
                    s_reg <= cy_reg;
                end
                2'd1:
                begin
                    c_reg <= -cy_reg;
                    s_reg <= cx_reg;
                end
                2'd2:
                begin
                    c_reg <= -cx_reg;
                    s_reg <= -cy_reg;
                end
                default:
                begin
                    c_reg <= cy_reg;
                    s_reg <= -cx_reg;
                end
            endcase
        end

        if (en)
        begin
            rd_reg <= mem[cnt_reg];
            n1_reg <= cnt_reg;
            l1_reg <= (cnt_reg == VIDX_W'(VERTEX_COUNT - 1));

            xc_reg <= $signed(rd_reg[63:32]) * c_reg;
            ys_reg <= $signed(rd_reg[31:0]) * s_reg;
            xs_reg <= $signed(rd_reg[63:32]) * s_reg;
            yc_reg <= $signed(rd_reg[31:0]) * c_reg;
            n2_reg <= n1_reg;
            l2_reg <= l1_reg;

            out_x_reg      <= sat32(wsum_x);
            out_y_reg      <= sat32(wsum_y);
            out_num_reg    <= n2_reg;
            out_last_reg   <= l2_reg;
            out_inside_reg <= inside_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.vertex_number = 6'(out_num_reg);
    assign res.world_x       = out_x_reg;
    assign res.world_y       = out_y_reg;
    assign res.inside_bounds = out_inside_reg;
    assign res.last_vertex   = out_last_reg;

endmodule

`default_nettype wire
